@@ rtl/situ_pkg.sv @@
// Package: shared constants and types for the sorted interval table.
`default_nettype none
package situ_pkg;
    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_TAG_BITS    = 16;

    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_UPDATE = 2'd2;
    localparam logic [1:0] FUNC_CLEAR  = 2'd3;

    localparam logic [1:0] OUT_DONE     = 2'd0;
    localparam logic [1:0] OUT_INVALID  = 2'd1;
    localparam logic [1:0] OUT_NOTFOUND = 2'd2;
    localparam logic [1:0] OUT_FULL     = 2'd3;

    localparam logic [1:0] ST_CONFIRMED = 2'd1;

    // Datapath commands issued by the controller
    typedef struct packed {
        logic load;      // capture the incoming item
        logic scan_tag;  // step the tag search
        logic scan_pos;  // step the placement search
        logic shift_rm;  // step the removal shift
        logic shift_in;  // step the insertion shift
        logic write_new; // write the new entry at the insert row
        logic cnt_inc;
        logic cnt_dec;
        logic cnt_clr;
        logic un_start;  // restart union walk
        logic un_step;   // step union walk
        logic ptr_clr;   // zero the walk pointer
    } t_cmd;

    // Datapath status returned to the controller
    typedef struct packed {
        logic ptr_end;   // pointer reached the walk limit
        logic ins_end;   // pointer passed the row after the last held row
        logic tag_hit;   // current entry tag matches
        logic pos_hit;   // current entry sorts at or after the new key
        logic full;
        logic key_bad;   // end not above start
    } t_sts;
endpackage
`default_nettype wire

@@ rtl/situ_if.sv @@
// Interfaces: valid/ready channels for items and results.
`default_nettype none
interface situ_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] start_ms;
    logic [31:0] end_ms;
    logic [1:0]  marker_state;
    logic [15:0] marker_tag;
    modport source (output valid, func, start_ms, end_ms, marker_state, marker_tag,
                    input ready);
    modport sink (input valid, func, start_ms, end_ms, marker_state, marker_tag,
                  output ready);
endinterface

interface situ_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  outcome;
    logic [5:0]  row;
    logic [6:0]  entry_count;
    logic [31:0] total_cut_ms;
    modport source (output valid, outcome, row, entry_count, total_cut_ms, input ready);
    modport sink (input valid, outcome, row, entry_count, total_cut_ms, output ready);
endinterface
`default_nettype wire

@@ rtl/situ_datapath.sv @@
// Datapath: entry memory, walk pointer, shifters and union accumulator.
`default_nettype none
module situ_datapath import situ_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int TAG_BITS    = DEF_TAG_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_sts             o_sts,
    input  wire logic [31:0] i_start,
    input  wire logic [31:0] i_end,
    input  wire logic [1:0]  i_state,
    input  wire logic [15:0] i_tag,
    output logic [$clog2(TABLE_DEPTH+1)-1:0] o_ptr,
    output logic [$clog2(TABLE_DEPTH+1)-1:0] o_count,
    output logic [31:0]      o_total
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = 32 + 32 + 2 + TAG_BITS;

    // Entry memory: {start, end, state, tag}; single write, single read port
    logic [EW-1:0] r_mem [TABLE_DEPTH];

    logic [31:0]       r_s, r_e;
    logic [1:0]        r_st;
    logic [TAG_BITS-1:0] r_tag;
    logic [CW-1:0]     r_cnt, r_ptr;
    logic [EW-1:0]     r_carry;   // entry moving along in a shift
    logic [EW-1:0]     r_rd;      // registered read: always the row at r_ptr
    logic [31:0]       r_ms, r_me, r_total;
    logic              r_open;

    logic [CW-1:0] n_ptr;
    logic [31:0]   rs, re;
    logic [1:0]    rst;
    logic [TAG_BITS-1:0] rtag;
    logic [AW-1:0] ra, wa;
    logic          we;
    logic [EW-1:0] wd;

    // Read is addressed by the next pointer so r_rd tracks the current row;
    // a write never lands on the row read in the same cycle
    assign ra = n_ptr[AW-1:0];
    assign rs   = r_rd[EW-1 -: 32];
    assign re   = r_rd[EW-33 -: 32];
    assign rst  = r_rd[TAG_BITS+1 -: 2];
    assign rtag = r_rd[TAG_BITS-1:0];

    always_comb begin
        o_sts.ptr_end = (r_ptr >= r_cnt);
        o_sts.ins_end = (r_ptr > r_cnt);
        o_sts.tag_hit = (rtag == r_tag);
        o_sts.pos_hit = (rs > r_s) || ((rs == r_s) && (re >= r_e));
        o_sts.full    = (r_cnt >= CW'(TABLE_DEPTH));
        o_sts.key_bad = (r_e <= r_s);
    end

    // Memory write select
    always_comb begin
        we = 1'b0;
        wa = r_ptr[AW-1:0];
        wd = r_carry;
        if (i_cmd.shift_rm) begin
            we = 1'b1;
            wa = AW'(r_ptr - CW'(1));
            wd = r_rd;
        end else if (i_cmd.shift_in) begin
            we = 1'b1;
            wd = r_carry;
        end else if (i_cmd.write_new) begin
            we = 1'b1;
            wd = {r_s, r_e, r_st, r_tag};
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[wa] <= wd;
        r_rd <= r_mem[ra];
    end

    // Walk pointer
    always_comb begin
        n_ptr = r_ptr;
        if (i_cmd.ptr_clr) n_ptr = '0;
        else if (i_cmd.scan_tag || i_cmd.scan_pos || i_cmd.shift_rm || i_cmd.shift_in ||
                 i_cmd.write_new || i_cmd.un_step)
            n_ptr = r_ptr + CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
            r_cnt <= '0;
        end else begin
            r_ptr <= n_ptr;
            if (i_cmd.cnt_clr) r_cnt <= '0;
            else if (i_cmd.cnt_inc) r_cnt <= r_cnt + CW'(1);
            else if (i_cmd.cnt_dec) r_cnt <= r_cnt - CW'(1);
        end
    end

    // Item capture and insertion carry
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_s   <= i_start;
            r_e   <= i_end;
            r_st  <= i_state;
            r_tag <= TAG_BITS'(i_tag);
        end
        if (i_cmd.write_new || i_cmd.shift_in) r_carry <= r_rd;
    end

    // Union walk: one entry per step
    always_ff @(posedge i_clk) begin
        if (i_cmd.un_start) begin
            r_open  <= 1'b0;
            r_total <= '0;
            r_ms    <= '0;
            r_me    <= '0;
        end else if (i_cmd.un_step) begin
            if (rst == ST_CONFIRMED && re > rs) begin
                if (!r_open) begin
                    r_ms <= rs; r_me <= re; r_open <= 1'b1;
                end else if (rs <= r_me) begin
                    if (re > r_me) r_me <= re;
                end else begin
                    r_total <= r_total + (r_me - r_ms);
                    r_ms <= rs; r_me <= re;
                end
            end
        end
    end

    assign o_ptr   = r_ptr;
    assign o_count = r_cnt;
    assign o_total = r_open ? r_total + (r_me - r_ms) : r_total;
endmodule
`default_nettype wire

@@ rtl/situ_ctrl.sv @@
// Controller: sequences search, shift and union walks for each item.
`default_nettype none
module situ_ctrl import situ_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_func,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_outcome,
    output logic [5:0]       o_row,
    output t_cmd             o_cmd,
    input  wire t_sts        i_sts,
    input  wire logic [$clog2(TABLE_DEPTH+1)-1:0] i_ptr
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FTAG  = 3'd1;
    localparam logic [2:0] S_RMV   = 3'd2;
    localparam logic [2:0] S_FPOS  = 3'd3;
    localparam logic [2:0] S_INS   = 3'd4;
    localparam logic [2:0] S_UNION = 3'd5;
    localparam logic [2:0] S_RES   = 3'd6;

    logic [2:0] r_state, n_state;
    logic [1:0] r_func, n_func, r_outc, n_outc;
    logic [5:0] r_row, n_row;
    logic       r_vld, n_vld;

    always_comb begin
        n_state = r_state; n_func = r_func; n_outc = r_outc; n_row = r_row;
        n_vld = r_vld && !i_out_ready;
        o_cmd = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = !r_vld || i_out_ready;
                if (i_in_valid && o_in_ready) begin
                    o_cmd.load = 1'b1;
                    o_cmd.ptr_clr = 1'b1;
                    n_func = i_func; n_outc = OUT_DONE; n_row = '0;
                    n_state = (i_func == FUNC_ADD) ? S_FPOS :
                              (i_func == FUNC_CLEAR) ? S_UNION : S_FTAG;
                    if (i_func == FUNC_CLEAR) begin
                        o_cmd.cnt_clr = 1'b1;
                        o_cmd.un_start = 1'b1;
                    end
                end
            end
            S_FTAG: begin
                if (i_sts.ptr_end) begin
                    n_outc = OUT_NOTFOUND;
                    o_cmd.ptr_clr = 1'b1; o_cmd.un_start = 1'b1;
                    n_state = S_UNION;
                end else if (i_sts.tag_hit) begin
                    n_row = 6'(i_ptr);
                    o_cmd.scan_tag = 1'b1;  // step past the hit row
                    n_state = S_RMV;
                end else o_cmd.scan_tag = 1'b1;
            end
            S_RMV: begin
                // copy row ptr to ptr-1 until the end, then drop count
                if (i_sts.ptr_end) begin
                    o_cmd.cnt_dec = 1'b1; o_cmd.ptr_clr = 1'b1;
                    if (r_func == FUNC_UPDATE) n_state = S_FPOS;
                    else begin
                        o_cmd.un_start = 1'b1; n_state = S_UNION;
                    end
                end else o_cmd.shift_rm = 1'b1;
            end
            S_FPOS: begin
                if (r_func == FUNC_ADD && i_sts.key_bad) begin
                    n_outc = OUT_INVALID;
                    o_cmd.un_start = 1'b1; n_state = S_UNION;
                end else if (r_func == FUNC_ADD && i_sts.full) begin
                    n_outc = OUT_FULL;
                    o_cmd.un_start = 1'b1; n_state = S_UNION;
                end else if (i_sts.ptr_end || i_sts.pos_hit) begin
                    n_row = 6'(i_ptr);
                    o_cmd.write_new = 1'b1;  // old row content goes to carry
                    n_state = S_INS;
                end else o_cmd.scan_pos = 1'b1;
            end
            S_INS: begin
                // carry lands at ptr and picks up the old row there; done once
                // ptr passes the row after the old last row
                if (i_sts.ins_end) begin
                    o_cmd.cnt_inc = 1'b1; o_cmd.ptr_clr = 1'b1;
                    o_cmd.un_start = 1'b1; n_state = S_UNION;
                end else o_cmd.shift_in = 1'b1;
            end
            S_UNION: begin
                if (i_sts.ptr_end) begin
                    if (r_outc != OUT_DONE) n_row = '0;
                    n_state = S_RES;
                end else o_cmd.un_step = 1'b1;
            end
            S_RES: begin
                if (!r_vld) begin
                    n_vld = 1'b1; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_vld <= 1'b0;
        end else begin
            r_state <= n_state; r_vld <= n_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        r_func <= n_func; r_outc <= n_outc; r_row <= n_row;
    end

    assign o_out_valid = r_vld;
    assign o_outcome = r_outc;
    assign o_row = r_row;
endmodule
`default_nettype wire

@@ rtl/sorted_interval_table_union_core.sv @@
// Top level: sorted interval table with union length of confirmed entries.
// Items are handled one at a time. Each walks the held entries one row per
// cycle through an entry memory with one write port and a registered read
// port: a tag or placement search, a shift of the rows behind the affected
// row, then a union walk over all held rows. The result sits in an output
// register; the next item can be taken no earlier than the cycle in which
// that result is taken.
`default_nettype none
module sorted_interval_table_union_core import situ_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int TAG_BITS    = DEF_TAG_BITS
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    situ_in_if.sink   i_item,
    situ_out_if.source o_res
);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    t_cmd cmd;
    t_sts sts;
    logic [CW-1:0] ptr, cnt;
    logic [31:0]   total;
    logic [1:0]    outc;
    logic [5:0]    row;
    logic [6:0]    r_cnt_out;
    logic [31:0]   r_total_out;

    situ_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(i_item.valid), .o_in_ready(i_item.ready), .i_func(i_item.func),
        .o_out_valid(o_res.valid), .i_out_ready(o_res.ready),
        .o_outcome(outc), .o_row(row),
        .o_cmd(cmd), .i_sts(sts), .i_ptr(ptr)
    );

    situ_datapath #(.TABLE_DEPTH(TABLE_DEPTH), .TAG_BITS(TAG_BITS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_sts(sts),
        .i_start(i_item.start_ms), .i_end(i_item.end_ms),
        .i_state(i_item.marker_state), .i_tag(i_item.marker_tag),
        .o_ptr(ptr), .o_count(cnt), .o_total(total)
    );

    // Latch count and union when the walk finishes
    always_ff @(posedge i_clk) begin
        if (!o_res.valid) begin
            r_cnt_out   <= 7'(cnt);
            r_total_out <= total;
        end
    end

    assign o_res.outcome      = outc;
    assign o_res.row          = row;
    assign o_res.entry_count  = r_cnt_out;
    assign o_res.total_cut_ms = r_total_out;
endmodule
`default_nettype wire

@@ rtl/situ_checker.sv @@
// Checker: port-level properties of the interval table core.
`default_nettype none
module situ_checker import situ_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic in_valid, in_ready, out_valid, out_ready,
    input wire logic [1:0] outcome,
    input wire logic [5:0] row,
    input wire logic [6:0] entry_count
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_row0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && outcome != OUT_DONE |-> row == 6'd0) else $error("row on refusal");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> entry_count <= 7'd64) else $error("count overflow");
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready) else $error("item overlap");
endmodule

bind sorted_interval_table_union_core situ_checker u_chk (
    .i_clk, .i_rst_n,
    .in_valid(i_item.valid), .in_ready(i_item.ready),
    .out_valid(o_res.valid), .out_ready(o_res.ready),
    .outcome(o_res.outcome), .row(o_res.row), .entry_count(o_res.entry_count)
);
`default_nettype wire
